[rtl/bgc_pkg.sv]
// Shared constants, types and helpers for the bipartite graph checker.
package bgc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VID_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int REG_IDX_W = 1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_VERTEX_COUNT = 1'b0,
        REG_START_VERTEX = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic edge_wr;
        logic walk_init;
        logic pick;
        logic expand;
        logic finish;
        logic clear_wr;
    } bgc_cmd_t;

    typedef struct packed {
        logic pending_any;
        logic walk_ok;
        logic clear_last;
        logic out_free;
    } bgc_status_t;

    // Index of the lowest set bit, halving the search window each step.
    function automatic logic [VID_W-1:0] first_set(input logic [MAX_VERTICES-1:0] bits);
        logic [MAX_VERTICES-1:0] x;
        logic [MAX_VERTICES-1:0] lo;
        logic [VID_W-1:0]        idx;
        int                      half;
        int                      lvl;
        x   = bits;
        idx = '0;
        for (lvl = VID_W - 1; lvl >= 0; lvl--)
        begin
            half = 1 << lvl;
            lo   = x & ((MAX_VERTICES'(1) << half) - MAX_VERTICES'(1));
            if (lo == '0)
            begin
                x        = x >> half;
                idx[lvl] = 1'b1;
            end
            else
            begin
                x = lo;
            end
        end
        return idx;
    endfunction

endpackage

[rtl/bgc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bgc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bgc_ctrl.sv]
// Controller state machine: edge loading, coloring walk, result hand-off, matrix clear.
module bgc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last_edge,
    input  bgc_pkg::bgc_status_t status,
    output logic                 in_ready,
    output bgc_pkg::bgc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_LOAD,
        S_PICK,
        S_EXPAND,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   in_fire;

    assign in_fire  = in_valid && in_ready_reg;
    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_CLEAR:  cmd.clear_wr = 1'b1;
            S_LOAD:
            begin
                cmd.edge_wr   = in_fire;
                cmd.walk_init = in_fire && last_edge;
            end
            S_PICK:   cmd.pick = status.pending_any && status.walk_ok;
            S_EXPAND: cmd.expand = 1'b1;
            S_FINISH: cmd.finish = status.out_free;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    if (status.clear_last)
                    begin
                        state_reg    <= S_LOAD;
                        in_ready_reg <= 1'b1;
                    end
                end
                S_LOAD:
                begin
                    if (in_fire && last_edge)
                    begin
                        state_reg    <= S_PICK;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_PICK:
                begin
                    if (status.pending_any && status.walk_ok)
                    begin
                        state_reg <= S_EXPAND;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_EXPAND: state_reg <= S_PICK;
                S_FINISH:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= S_CLEAR;
                    end
                end
                default:
                begin
                    state_reg    <= S_CLEAR;
                    in_ready_reg <= 1'b0;
                end
            endcase
        end
    end

    a_ready_only_loading: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready_reg |-> state_reg == S_LOAD)
        else $error("input ready outside load state");

    a_last_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_edge) |=> (state_reg == S_PICK && !in_ready_reg))
        else $error("last edge did not start the walk");

endmodule

[rtl/bgc_dp.sv]
// Datapath: config registers, adjacency matrix columns, walk bitmaps, result register.
module bgc_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr,
    input  logic [bgc_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [bgc_pkg::CNT_W-1:0]            cfg_data,
    input  logic [bgc_pkg::VID_W-1:0]            end_a,
    input  logic [bgc_pkg::VID_W-1:0]            end_b,
    input  bgc_pkg::bgc_cmd_t                    cmd,
    input  logic                                 out_ready,
    output bgc_pkg::bgc_status_t                 status,
    output logic                                 out_valid,
    output logic                                 is_bipartite,
    output logic [bgc_pkg::MAX_VERTICES-1:0]     color_map,
    output logic [bgc_pkg::MAX_VERTICES-1:0]     reached_map,
    output logic                                 bad_edge_seen
);

    localparam int NV = bgc_pkg::MAX_VERTICES;
    localparam int VW = bgc_pkg::VID_W;
    localparam int CW = bgc_pkg::CNT_W;

    logic [CW-1:0] vc_reg;
    logic [VW-1:0] sv_reg;
    logic [CW-1:0] cnt_eff;
    logic [VW-1:0] start_eff;
    logic          edge_bad;
    logic          edge_ok;

    logic [NV-1:0] mask_next;
    logic [NV-1:0] mask_reg;
    logic [NV-1:0] visited_reg;
    logic [NV-1:0] color_reg;
    logic [NV-1:0] done_reg;
    logic          ok_reg;
    logic          bad_reg;
    logic [VW-1:0] cur_v_reg;
    logic [VW-1:0] clr_cnt_reg;

    logic [NV-1:0] pending;
    logic [VW-1:0] pick_idx;
    logic [NV-1:0] row_data;
    logic [NV-1:0] nb;
    logic [NV-1:0] seen_nb;
    logic          vcol;
    logic          conflict;

    logic          out_valid_reg;
    logic          is_bip_reg;
    logic [NV-1:0] color_out_reg;
    logic [NV-1:0] reached_out_reg;
    logic          bad_out_reg;

    // Effective count clamps to 1..MAX_VERTICES; start saturates to count-1.
    always_comb
    begin
        if (vc_reg == '0)
        begin
            cnt_eff = CW'(1);
        end
        else if (vc_reg > CW'(NV))
        begin
            cnt_eff = CW'(NV);
        end
        else
        begin
            cnt_eff = vc_reg;
        end
        if (CW'(sv_reg) >= cnt_eff)
        begin
            start_eff = VW'(cnt_eff - CW'(1));
        end
        else
        begin
            start_eff = sv_reg;
        end
        for (int i = 0; i < NV; i++)
        begin
            mask_next[i] = CW'(i) < cnt_eff;
        end
    end

    assign edge_bad = (CW'(end_a) >= cnt_eff) || (CW'(end_b) >= cnt_eff);
    assign edge_ok  = cmd.edge_wr && !edge_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= CW'(NV);
            sv_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (bgc_pkg::reg_idx_t'(cfg_index))
                bgc_pkg::REG_VERTEX_COUNT: vc_reg <= cfg_data;
                bgc_pkg::REG_START_VERTEX: sv_reg <= cfg_data[VW-1:0];
                default: ;
            endcase
        end
    end

    // Bit (r, k) of the matrix lives in column RAM k at address r.
    for (genvar k = 0; k < NV; k++)
    begin : g_col
        logic          we;
        logic [VW-1:0] wa;
        logic          wd;

        always_comb
        begin
            if (cmd.clear_wr)
            begin
                we = 1'b1;
                wa = clr_cnt_reg;
                wd = 1'b0;
            end
            else
            begin
                we = edge_ok && (end_a == VW'(k) || end_b == VW'(k));
                wa = (end_b == VW'(k)) ? end_a : end_b;
                wd = 1'b1;
            end
        end

        bgc_ram #(
            .WIDTH(1),
            .DEPTH(NV)
        ) u_col (
            .clk   (clk),
            .we    (we),
            .waddr (wa),
            .wdata (wd),
            .raddr (pick_idx),
            .rdata (row_data[k])
        );
    end

    assign pending  = visited_reg & ~done_reg;
    assign pick_idx = bgc_pkg::first_set(pending);

    assign nb       = row_data & mask_reg;
    assign vcol     = color_reg[cur_v_reg];
    assign seen_nb  = nb & visited_reg;
    assign conflict = vcol ? |(seen_nb & color_reg) : |(seen_nb & ~color_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            visited_reg <= '0;
            color_reg   <= '0;
            done_reg    <= '0;
            ok_reg      <= 1'b1;
            bad_reg     <= 1'b0;
            cur_v_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.edge_wr && edge_bad)
            begin
                bad_reg <= 1'b1;
            end
            if (cmd.walk_init)
            begin
                mask_reg    <= mask_next;
                visited_reg <= NV'(1) << start_eff;
                color_reg   <= '0;
                done_reg    <= '0;
                ok_reg      <= 1'b1;
            end
            if (cmd.pick)
            begin
                cur_v_reg          <= pick_idx;
                done_reg[pick_idx] <= 1'b1;
            end
            if (cmd.expand)
            begin
                visited_reg <= visited_reg | nb;
                if (!vcol)
                begin
                    color_reg <= color_reg | (nb & ~visited_reg);
                end
                if (conflict)
                begin
                    ok_reg <= 1'b0;
                end
            end
            if (cmd.finish)
            begin
                bad_reg <= 1'b0;
            end
            if (cmd.clear_wr)
            begin
                if (clr_cnt_reg == VW'(NV - 1))
                begin
                    clr_cnt_reg <= '0;
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + VW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            is_bip_reg      <= ok_reg;
            color_out_reg   <= ok_reg ? color_reg : '0;
            reached_out_reg <= ok_reg ? visited_reg : '0;
            bad_out_reg     <= bad_reg;
        end
    end

    assign status.pending_any = |pending;
    assign status.walk_ok     = ok_reg;
    assign status.clear_last  = clr_cnt_reg == VW'(NV - 1);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign is_bipartite  = is_bip_reg;
    assign color_map     = color_out_reg;
    assign reached_map   = reached_out_reg;
    assign bad_edge_seen = bad_out_reg;

    a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg & ~visited_reg) == '0)
        else $error("processed vertex not marked reached");

    a_color_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (color_reg & ~visited_reg) == '0)
        else $error("colored vertex not marked reached");

    a_pick_reached: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |=> (visited_reg[cur_v_reg] && done_reg[cur_v_reg]))
        else $error("picked vertex not reached");

    a_fail_zero_maps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !is_bip_reg) |-> (color_out_reg == '0 && reached_out_reg == '0))
        else $error("maps not cleared on odd cycle");

endmodule

[rtl/bipartite_graph_check.sv]
// Top level of the bipartite graph checker: controller plus datapath.
// Edges: one transfer per cycle while loading, stored into a 64x64 adjacency matrix.
// After the last edge, the coloring walk handles each reached vertex in a pick state
// (row read) and an expand state, stopping early on a conflict, then registers the
// result. A clearing sweep over all 64 matrix rows then runs before the next edge is taken.
// Reset is asynchronous active low; the same clearing sweep follows reset.
module bipartite_graph_check (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bgc_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [bgc_pkg::CNT_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bgc_pkg::VID_W-1:0]            end_a,
    input  logic [bgc_pkg::VID_W-1:0]            end_b,
    input  logic                                 last_edge,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 is_bipartite,
    output logic [bgc_pkg::MAX_VERTICES-1:0]     color_map,
    output logic [bgc_pkg::MAX_VERTICES-1:0]     reached_map,
    output logic                                 bad_edge_seen
);

    bgc_pkg::bgc_cmd_t    cmd;
    bgc_pkg::bgc_status_t status;

    assign cfg_ready = 1'b1;

    bgc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_edge (last_edge),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    bgc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .end_a         (end_a),
        .end_b         (end_b),
        .cmd           (cmd),
        .out_ready     (out_ready),
        .status        (status),
        .out_valid     (out_valid),
        .is_bipartite  (is_bipartite),
        .color_map     (color_map),
        .reached_map   (reached_map),
        .bad_edge_seen (bad_edge_seen)
    );

endmodule
